>>> hw/rtl/event_trace_ring_buffer_macros.svh
// ----------------------------------------------------------------------------
// Event trace ring buffer assertion macros
// Shared concurrent assertion forms for the trace buffer RTL.
// ----------------------------------------------------------------------------
`ifndef EVENT_TRACE_RING_BUFFER_MACROS_SVH
`define EVENT_TRACE_RING_BUFFER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ETRB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("etrb assertion failed");

// Next-cycle implication, disabled during reset.
`define ETRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("etrb assertion failed");

`endif

>>> hw/rtl/etrb_pkg.sv
// ----------------------------------------------------------------------------
// Event trace ring buffer package
// Item kinds, entry layout and the task id encoding shared by the RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etrb_pkg;

	localparam int unsigned DEPTH_DEF = 64;

	localparam logic [1:0] KIND_SWITCH   = 2'd0;
	localparam logic [1:0] KIND_MIGRATE  = 2'd1;
	localparam logic [1:0] KIND_SNAPSHOT = 2'd2;
	localparam logic [1:0] KIND_CLEAR    = 2'd3;

	localparam logic [15:0] ID_NONE = 16'hFFFF;
	localparam logic [15:0] ID_MAX  = 16'hFFFE;

	localparam logic EV_SWITCH  = 1'b0;
	localparam logic EV_MIGRATE = 1'b1;

	typedef struct packed {
		logic        ev;
		logic [7:0]  from_cpu;
		logic [7:0]  cpu;
		logic [15:0] next_id;
		logic [15:0] prev_id;
	} info_t;

	typedef struct packed {
		logic        en;
		logic [63:0] stamp;
		info_t       info;
	} wr_req_t;

	function automatic logic [15:0] id_field(input logic present, input logic [31:0] id);
		logic [15:0] r;
		if (!present) begin
			r = ID_NONE;
		end else if (id > {16'd0, ID_MAX}) begin
			r = ID_MAX;
		end else begin
			r = id[15:0];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/etrb_store.sv
// ----------------------------------------------------------------------------
// Event trace entry store
// Timestamp and info arrays with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etrb_store #(
	parameter int unsigned DEPTH = etrb_pkg::DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  etrb_pkg::wr_req_t wr,
	input  logic [AW-1:0]    wr_addr,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [63:0]      rd_time,
	output etrb_pkg::info_t  rd_info
);

	logic [63:0]     time_mem [DEPTH];
	etrb_pkg::info_t info_mem [DEPTH];
	logic [63:0]     rd_time_q;
	etrb_pkg::info_t rd_info_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			time_mem[wr_addr] <= wr.stamp;
			info_mem[wr_addr] <= wr.info;
		end
		if (rd_en) begin
			rd_time_q <= time_mem[rd_addr];
			rd_info_q <= info_mem[rd_addr];
		end
	end

	assign rd_time = rd_time_q;
	assign rd_info = rd_info_q;

endmodule

>>> hw/rtl/event_trace_ring_buffer.sv
// A snapshot item is taken in ST_IDLE; its first result is then registered in ST_SNAP once the output slot is free.
// A new item can be taken every cycle while no snapshot is read out (in_stall is high in ST_SNAP).
// A snapshot returning N entries gives N results, or a single empty result when none are copied,
// loading one result per cycle while the output slot is free (not stalled).
// Reset clears the counter, trace enable and handshake state; entries stay
// undefined until written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Event trace ring buffer
// Overwriting circular buffer of scheduler events with in-order snapshot readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "event_trace_ring_buffer_macros.svh"

module event_trace_ring_buffer #(
	parameter int unsigned DEPTH = etrb_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] timestamp,
	input  logic        first_task_present,
	input  logic [31:0] first_task_id,
	input  logic        second_task_present,
	input  logic [31:0] second_task_id,
	input  logic [7:0]  dest_cpu,
	input  logic [7:0]  source_cpu,
	input  logic [31:0] read_limit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        entry_valid,
	output logic [63:0] entry_time,
	output logic [15:0] entry_prev_id,
	output logic [15:0] entry_next_id,
	output logic [7:0]  entry_cpu,
	output logic [7:0]  entry_prev_cpu,
	output logic        entry_event,
	output logic [6:0]  copied_count,
	output logic        last_of_run
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic {
		ST_IDLE,
		ST_SNAP
	} state_t;

	state_t          state_q;
	logic            trace_enable_q;
	logic [63:0]     count_q;
	logic [AW-1:0]   wptr_q;
	logic [CW-1:0]   ret_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   n_q;
	logic [AW-1:0]   rd_ptr_q;
	logic            empty_q;
	logic            out_valid_q;
	logic            entry_valid_q;
	logic [6:0]      copied_q;
	logic            last_q;

	logic            in_acc;
	logic            snap_acc;
	logic            slot_free;
	logic            load;
	logic            rd_en;
	logic [CW-1:0]   n_start;
	logic [AW-1:0]   start_slot;
	logic [AW-1:0]   wptr_next;
	logic [AW-1:0]   rd_ptr_next;
	logic [15:0]     first_id;
	etrb_pkg::wr_req_t wr;
	logic [63:0]     rd_time;
	etrb_pkg::info_t rd_info;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign snap_acc  = in_acc && (kind == etrb_pkg::KIND_SNAPSHOT);
	assign slot_free = !out_valid_q || !out_stall;
	assign load      = (state_q == ST_SNAP) && slot_free;
	assign rd_en     = load && !empty_q;

	assign n_start    = (32'(ret_q) > read_limit) ? read_limit[CW-1:0] : ret_q;
	assign start_slot = (ret_q == CW'(DEPTH)) ? wptr_q : '0;
	assign wptr_next  = ((wptr_q == AW'(DEPTH - 1)) || (&count_q)) ? '0 : wptr_q + AW'(1);
	assign rd_ptr_next = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);

	assign first_id = etrb_pkg::id_field(first_task_present, first_task_id);

	always_comb begin
		wr.en    = in_acc && trace_enable_q &&
			((kind == etrb_pkg::KIND_SWITCH) || (kind == etrb_pkg::KIND_MIGRATE));
		wr.stamp = timestamp;
		wr.info.cpu     = dest_cpu;
		wr.info.prev_id = first_id;
		if (kind == etrb_pkg::KIND_MIGRATE) begin
			wr.info.ev       = etrb_pkg::EV_MIGRATE;
			wr.info.from_cpu = source_cpu;
			wr.info.next_id  = first_id;
		end else begin
			wr.info.ev       = etrb_pkg::EV_SWITCH;
			wr.info.from_cpu = dest_cpu;
			wr.info.next_id  = etrb_pkg::id_field(second_task_present, second_task_id);
		end
	end

	etrb_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.wr      (wr),
		.wr_addr (wptr_q),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q),
		.rd_time (rd_time),
		.rd_info (rd_info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			trace_enable_q <= 1'b0;
			count_q        <= '0;
			wptr_q         <= '0;
			ret_q          <= '0;
			rem_q          <= '0;
			n_q            <= '0;
			rd_ptr_q       <= '0;
			empty_q        <= 1'b0;
			out_valid_q    <= 1'b0;
			entry_valid_q  <= 1'b0;
			copied_q       <= '0;
			last_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				trace_enable_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall && !load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (kind) inside
							etrb_pkg::KIND_SWITCH, etrb_pkg::KIND_MIGRATE: begin
								if (trace_enable_q) begin
									count_q <= count_q + 64'd1;
									wptr_q  <= wptr_next;
									if (&count_q) begin
										ret_q <= '0;
									end else if (ret_q != CW'(DEPTH)) begin
										ret_q <= ret_q + CW'(1);
									end
								end
							end
							etrb_pkg::KIND_SNAPSHOT: begin
								n_q      <= n_start;
								rem_q    <= n_start;
								rd_ptr_q <= start_slot;
								empty_q  <= (n_start == '0);
								state_q  <= ST_SNAP;
							end
							default: begin
								count_q <= '0;
								wptr_q  <= '0;
								ret_q   <= '0;
							end
						endcase
					end
				end
				ST_SNAP: begin
					if (slot_free) begin
						out_valid_q   <= 1'b1;
						entry_valid_q <= !empty_q;
						copied_q      <= empty_q ? 7'd0 : 7'(n_q);
						last_q        <= empty_q || (rem_q == CW'(1));
						if (!empty_q) begin
							rem_q    <= rem_q - CW'(1);
							rd_ptr_q <= rd_ptr_next;
						end
						if (empty_q || (rem_q == CW'(1))) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign entry_valid    = entry_valid_q;
	assign entry_time     = entry_valid_q ? rd_time : '0;
	assign entry_prev_id  = entry_valid_q ? rd_info.prev_id : '0;
	assign entry_next_id  = entry_valid_q ? rd_info.next_id : '0;
	assign entry_cpu      = entry_valid_q ? rd_info.cpu : '0;
	assign entry_prev_cpu = entry_valid_q ? rd_info.from_cpu : '0;
	assign entry_event    = entry_valid_q ? rd_info.ev : 1'b0;
	assign copied_count   = copied_q;
	assign last_of_run    = last_q;

	`ETRB_ASSERT_IMPLY(a_ret_bound, clk, arst_n, 1'b1, ret_q <= CW'(DEPTH))
	`ETRB_ASSERT_IMPLY(a_wptr_bound, clk, arst_n, 1'b1, wptr_q <= AW'(DEPTH - 1))
	`ETRB_ASSERT_IMPLY(a_empty_is_last, clk, arst_n, out_valid_q && !entry_valid_q, last_q)
	`ETRB_ASSERT_IMPLY(a_snap_has_work, clk, arst_n, (state_q == ST_SNAP) && !empty_q, rem_q != '0)
	`ETRB_ASSERT_NEXT(a_snap_start, clk, arst_n, snap_acc, state_q == ST_SNAP)

endmodule

>>> verif/tb_event_trace_ring_buffer.sv
// ----------------------------------------------------------------------------
// Event trace ring buffer testbench
// Drives switch, migrate, snapshot and clear items through the valid/stall
// handshake with random gaps and stalls. An internal ring model predicts
// every snapshot entry, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_event_trace_ring_buffer;

	localparam int unsigned RING_DEPTH = etrb_pkg::DEPTH_DEF;
	localparam int unsigned RANDOM_ITEMS = 330;
	localparam int unsigned DRAIN_CYCLES = RING_DEPTH + 8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] stamp;
		logic        fp;
		logic [31:0] fid;
		logic        sp;
		logic [31:0] sid;
		logic [7:0]  dcpu;
		logic [7:0]  scpu;
		logic [31:0] limit;
	} sched_item_t;

	typedef struct packed {
		logic            valid;
		logic [63:0]     stamp;
		etrb_pkg::info_t info;
		logic [6:0]      count;
		logic            last;
	} trace_entry_t;

	typedef enum logic { ROW_ITEM, ROW_CFG } row_op_t;

	typedef struct packed {
		row_op_t     op;
		logic        enable;
		sched_item_t it;
		logic        empty_snap;
	} dir_row_t;

	localparam trace_entry_t EMPTY_SNAP = '{
		valid: 1'b0, stamp: 64'd0, info: '0, count: 7'd0, last: 1'b1
	};

	localparam int unsigned DIR_ROWS = 22;

	localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SNAPSHOT, 64'd0, 1'b0, 32'd0, 1'b0, 32'd0,
			8'd0, 8'd0, 32'hFFFF_FFFF}, 1'b1},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SWITCH, 64'h1234, 1'b1, 32'd7, 1'b1, 32'd9,
			8'd3, 8'd4, 32'd0}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SNAPSHOT, 64'd0, 1'b0, 32'd0, 1'b0, 32'd0,
			8'd0, 8'd0, 32'd5}, 1'b1},
		'{ROW_CFG, 1'b1, '0, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SWITCH, 64'd0, 1'b0, 32'd0, 1'b1, 32'd0,
			8'd0, 8'd0, 32'd0}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SWITCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 8'hFF, 8'hAA, 32'hFFFF_FFFF}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_MIGRATE, 64'h8000_0000_0000_0001, 1'b1,
			32'h0000_FFFE, 1'b1, 32'h1234, 8'h01, 8'hFF, 32'd3}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_MIGRATE, 64'd5, 1'b0, 32'd5, 1'b0, 32'd0,
			8'h80, 8'h00, 32'd0}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SWITCH, 64'd6, 1'b1, 32'h0000_FFFF, 1'b1,
			32'h0001_0000, 8'h7F, 8'h01, 32'd1}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SNAPSHOT, 64'd0, 1'b0, 32'd0, 1'b0, 32'd0,
			8'd0, 8'd0, 32'd0}, 1'b1},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SNAPSHOT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'd2}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SNAPSHOT, 64'd0, 1'b0, 32'd0, 1'b0, 32'd0,
			8'd0, 8'd0, 32'hFFFF_FFFF}, 1'b0},
		'{ROW_CFG, 1'b0, '0, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_MIGRATE, 64'd77, 1'b1, 32'd11, 1'b0, 32'd0,
			8'd5, 8'd6, 32'd0}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_CLEAR, 64'd0, 1'b0, 32'd0, 1'b0, 32'd0,
			8'd0, 8'd0, 32'd0}, 1'b0},
		'{ROW_CFG, 1'b1, '0, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SNAPSHOT, 64'd0, 1'b0, 32'd0, 1'b0, 32'd0,
			8'd0, 8'd0, 32'hFFFF_FFFF}, 1'b1},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_MIGRATE, 64'd1000, 1'b1, 32'd3, 1'b0, 32'd0,
			8'd2, 8'd9, 32'd0}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SNAPSHOT, 64'd0, 1'b0, 32'd0, 1'b0, 32'd0,
			8'd0, 8'd0, 32'd1}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF}, 1'b0},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SNAPSHOT, 64'd0, 1'b0, 32'd0, 1'b0, 32'd0,
			8'd0, 8'd0, 32'd1}, 1'b1},
		'{ROW_ITEM, 1'b0, '{etrb_pkg::KIND_SWITCH, 64'd42, 1'b1, 32'd100, 1'b1, 32'd200,
			8'd12, 8'd34, 32'd0}, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic [63:0] timestamp = '0;
	logic        first_task_present = 1'b0;
	logic [31:0] first_task_id = '0;
	logic        second_task_present = 1'b0;
	logic [31:0] second_task_id = '0;
	logic [7:0]  dest_cpu = '0;
	logic [7:0]  source_cpu = '0;
	logic [31:0] read_limit = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        entry_valid;
	logic [63:0] entry_time;
	logic [15:0] entry_prev_id;
	logic [15:0] entry_next_id;
	logic [7:0]  entry_cpu;
	logic [7:0]  entry_prev_cpu;
	logic        entry_event;
	logic [6:0]  copied_count;
	logic        last_of_run;

	logic            trace_on = 1'b0;
	logic [63:0]     rec_count = '0;
	logic [63:0]     stamp_ring [RING_DEPTH];
	etrb_pkg::info_t info_ring [RING_DEPTH];
	trace_entry_t    expected_q [$];
	int unsigned     err_cnt = 0;
	int unsigned     hold_left = 0;
	logic            fast_phase = 1'b0;

	event_trace_ring_buffer #(
		.DEPTH(RING_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.timestamp(timestamp),
		.first_task_present(first_task_present),
		.first_task_id(first_task_id),
		.second_task_present(second_task_present),
		.second_task_id(second_task_id),
		.dest_cpu(dest_cpu),
		.source_cpu(source_cpu),
		.read_limit(read_limit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.entry_valid(entry_valid),
		.entry_time(entry_time),
		.entry_prev_id(entry_prev_id),
		.entry_next_id(entry_next_id),
		.entry_cpu(entry_cpu),
		.entry_prev_cpu(entry_prev_cpu),
		.entry_event(entry_event),
		.copied_count(copied_count),
		.last_of_run(last_of_run)
	);

	always #4 clk = ~clk;

	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [15:0] sat_id(logic present, logic [31:0] id);
		if (!present) begin
			return etrb_pkg::ID_NONE;
		end
		return (id > {16'd0, etrb_pkg::ID_MAX}) ? etrb_pkg::ID_MAX : id[15:0];
	endfunction

	function automatic void predict_item(sched_item_t it);
		etrb_pkg::info_t rec;
		trace_entry_t    res;
		logic [63:0]     held;
		logic [63:0]     take;
		logic [63:0]     first;
		logic [63:0]     i;
		int unsigned     slot;
		rec = '0;
		case (it.kind) inside
			etrb_pkg::KIND_SWITCH, etrb_pkg::KIND_MIGRATE: begin
				if (trace_on) begin
					rec.cpu = it.dcpu;
					rec.prev_id = sat_id(it.fp, it.fid);
					if (it.kind == etrb_pkg::KIND_MIGRATE) begin
						rec.ev = etrb_pkg::EV_MIGRATE;
						rec.next_id = rec.prev_id;
						rec.from_cpu = it.scpu;
					end else begin
						rec.ev = etrb_pkg::EV_SWITCH;
						rec.next_id = sat_id(it.sp, it.sid);
						rec.from_cpu = it.dcpu;
					end
					slot = int'(rec_count % RING_DEPTH);
					stamp_ring[slot] = it.stamp;
					info_ring[slot] = rec;
					rec_count = rec_count + 64'd1;
				end
			end
			etrb_pkg::KIND_CLEAR: begin
				rec_count = '0;
			end
			etrb_pkg::KIND_SNAPSHOT: begin
				held = (rec_count < RING_DEPTH) ? rec_count : 64'(RING_DEPTH);
				take = (held < {32'd0, it.limit}) ? held : {32'd0, it.limit};
				first = rec_count - held;
				if (take == 0) begin
					expected_q.push_back(EMPTY_SNAP);
				end
				for (i = 0; i < take; i++) begin
					slot = int'((first + i) % RING_DEPTH);
					res.valid = 1'b1;
					res.stamp = stamp_ring[slot];
					res.info = info_ring[slot];
					res.count = 7'(take);
					res.last = (i + 1 == take);
					expected_q.push_back(res);
				end
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			err_cnt++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		trace_entry_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				err_cnt++;
				$error("result with no item pending");
			end else begin
				want = expected_q.pop_front();
				check_field("entry_valid", want.valid, entry_valid);
				check_field("entry_time", want.stamp, entry_time);
				check_field("entry_prev_id", want.info.prev_id, entry_prev_id);
				check_field("entry_next_id", want.info.next_id, entry_next_id);
				check_field("entry_cpu", want.info.cpu, entry_cpu);
				check_field("entry_prev_cpu", want.info.from_cpu, entry_prev_cpu);
				check_field("entry_event", want.info.ev, entry_event);
				check_field("copied_count", want.count, copied_count);
				check_field("last_of_run", want.last, last_of_run);
			end
			hold_left = fast_phase ? 0 : $urandom_range(0, 5);
		end else if (!out_valid && hold_left == 0 && !fast_phase &&
				$urandom_range(0, 7) == 0) begin
			hold_left = $urandom_range(1, 5);
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(sched_item_t it, logic empty_snap);
		int unsigned gap;
		gap = fast_phase ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= it.kind;
		timestamp <= it.stamp;
		first_task_present <= it.fp;
		first_task_id <= it.fid;
		second_task_present <= it.sp;
		second_task_id <= it.sid;
		dest_cpu <= it.dcpu;
		source_cpu <= it.scpu;
		read_limit <= it.limit;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (empty_snap) begin
			expected_q.push_back(EMPTY_SNAP);
		end else begin
			predict_item(it);
		end
	endtask

	// Records cause no result, so the task idles after the queue drains to let the last one settle.
	task automatic set_trace(logic on);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= on;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		trace_on = on;
	endtask

	function automatic logic [31:0] rand_id();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 65534);
			2: return 32'h0000_FFFE;
			3: return 32'h0000_FFFF;
			default: return $urandom_range(65536, 70000);
		endcase
	endfunction

	function automatic sched_item_t rand_item(logic [1:0] k);
		sched_item_t it;
		it.kind = k;
		it.stamp = {$urandom, $urandom};
		it.fp = ($urandom_range(0, 4) != 0);
		it.fid = rand_id();
		it.sp = ($urandom_range(0, 4) != 0);
		it.sid = rand_id();
		it.dcpu = 8'($urandom);
		it.scpu = 8'($urandom);
		case ($urandom_range(0, 5))
			0: it.limit = 32'd0;
			1: it.limit = $urandom_range(1, 8);
			2: it.limit = $urandom_range(1, 64);
			3: it.limit = $urandom_range(65, 1000);
			4: it.limit = $urandom;
			default: it.limit = 32'hFFFF_FFFF;
		endcase
		return it;
	endfunction

	initial begin
		sched_item_t it;
		int unsigned sent;
		int unsigned phase;
		int unsigned burst;
		sent = 0;
		phase = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TBL[r]) begin
			if (DIR_TBL[r].op == ROW_CFG) begin
				set_trace(DIR_TBL[r].enable);
			end else begin
				send_item(DIR_TBL[r].it, DIR_TBL[r].empty_snap);
			end
		end

		while (sent < RANDOM_ITEMS) begin
			if (phase > 0 && $urandom_range(0, 2) == 0) begin
				set_trace($urandom_range(0, 4) != 0);
			end
			fast_phase = ($urandom_range(0, 3) == 0);
			burst = (phase == 0 || $urandom_range(0, 3) == 0) ?
				$urandom_range(64, 90) : $urandom_range(0, 20);
			if (burst > RANDOM_ITEMS - sent) begin
				burst = RANDOM_ITEMS - sent;
			end
			repeat (burst) begin
				if ($urandom_range(0, 9) == 0) begin
					it = rand_item(2'($urandom_range(0, 3)));
				end else begin
					it = rand_item($urandom_range(0, 1) ?
						etrb_pkg::KIND_MIGRATE : etrb_pkg::KIND_SWITCH);
				end
				sent++;
				send_item(it, 1'b0);
			end
			send_item(rand_item(etrb_pkg::KIND_SNAPSHOT), 1'b0);
			sent++;
			if ($urandom_range(0, 5) == 0) begin
				send_item(rand_item(etrb_pkg::KIND_CLEAR), 1'b0);
				send_item(rand_item(etrb_pkg::KIND_SNAPSHOT), 1'b0);
				sent += 2;
			end
			phase++;
		end

		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/etrb_pkg.sv
hw/rtl/etrb_store.sv
hw/rtl/event_trace_ring_buffer.sv
verif/tb_event_trace_ring_buffer.sv
